// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the RTL queue. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Whenever pre holds at a clock edge, post must hold at the same edge.
`define ASSERT_IMPLIES(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("implication check failed");

// Whenever pre holds at a clock edge, post must hold at the following edge.
`define ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(name, clk, rst, pre, post)
`define ASSERT_NEXT(name, clk, rst, pre, post)

`endif

`endif

// ----- hdl/dctm_pkg.sv -----
`timescale 1ns / 1ps

package dctm_pkg;

  // Field and bus widths.
  localparam int RAW_W   = 12;
  localparam int VAL_W   = 12;
  localparam int TDATA_W = 16;

  // Defaults for the top-level parameters.
  localparam int WINDOW_DEF      = 10;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Largest scaled sample, reached by a full-scale voltage reading.
  localparam int SCALED_MAX = 3364;

  // Voltage: ((raw * 33000) >> 12 + 650) / 10, the divide by ten done as
  // a multiply by 52429 and a shift by 19, exact for the operand range here.
  localparam int VOLT_MUL    = 33000;
  localparam int VOLT_SHIFT  = 12;
  localparam int VOLT_OFFSET = 650;
  localparam int DIV10_MUL   = 52429;
  localparam int DIV10_SHIFT = 19;

  // Current: (raw * 3300) >> 14.
  localparam int CUR_MUL   = 3300;
  localparam int CUR_SHIFT = 14;

  localparam int MUL_W   = 16;
  localparam int PROD1_W = RAW_W + MUL_W;
  localparam int OFS_W   = 16;
  localparam int PROD2_W = 32;

  // Channel codes.
  localparam logic CH_VOLT = 1'b0;
  localparam logic CH_CUR  = 1'b1;

  // Bits needed to hold the running sum of one full window.
  function automatic int sum_width(input int window);
    return $clog2(window * SCALED_MAX + 1);
  endfunction

  // Queue entry: {channel, sum, min, max}.
  function automatic int entry_width(input int window);
    return 1 + sum_width(window) + 2 * VAL_W;
  endfunction

endpackage

// ----- hdl/dctm_front.sv -----
`timescale 1ns / 1ps

module dctm_front import dctm_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_channel,
  input  logic [RAW_W-1:0]                in_raw,
  input  logic                            queue_full,
  output logic                            push,
  output logic [entry_width(WINDOW)-1:0]  push_data
);

  localparam int SW    = sum_width(WINDOW);
  localparam int CNT_W = $clog2(WINDOW);

  logic                 s1_valid;
  logic                 s1_ch;
  logic [PROD1_W-1:0]   s1_prod;
  logic                 s2_valid;
  logic                 s2_ch;
  logic [PROD2_W-1:0]   s2_prod;
  logic [VAL_W-1:0]     s2_cur;

  logic [SW-1:0]        win_sum [2];
  logic [VAL_W-1:0]     win_min [2];
  logic [VAL_W-1:0]     win_max [2];
  logic [CNT_W-1:0]     win_cnt [2];

  logic [MUL_W-1:0]     coef;
  logic [OFS_W-1:0]     volt_ofs;
  logic [VAL_W-1:0]     scaled;
  logic [SW-1:0]        sum_next;
  logic [VAL_W-1:0]     min_next;
  logic [VAL_W-1:0]     max_next;
  logic                 last;
  logic                 adv;

  assign coef     = (in_channel == CH_CUR) ? MUL_W'(CUR_MUL) : MUL_W'(VOLT_MUL);
  assign volt_ofs = OFS_W'(s1_prod[PROD1_W-1:VOLT_SHIFT]) + OFS_W'(VOLT_OFFSET);

  // Accumulate stage works on the scaled sample of the second stage.
  assign scaled   = (s2_ch == CH_CUR) ? s2_cur : s2_prod[DIV10_SHIFT +: VAL_W];
  assign sum_next = win_sum[s2_ch] + SW'(scaled);
  assign min_next = (scaled < win_min[s2_ch]) ? scaled : win_min[s2_ch];
  assign max_next = (scaled > win_max[s2_ch]) ? scaled : win_max[s2_ch];
  assign last     = (win_cnt[s2_ch] == CNT_W'(WINDOW - 1));

  // The whole front holds only when a finished window finds the queue full.
  assign adv       = !(s2_valid && last && queue_full);
  assign in_ready  = adv;
  assign push      = s2_valid && last && !queue_full;
  assign push_data = {s2_ch, sum_next, min_next, max_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ch   <= in_channel;
      s1_prod <= PROD1_W'(in_raw) * PROD1_W'(coef);
      s2_ch   <= s1_ch;
      s2_prod <= PROD2_W'(volt_ofs) * PROD2_W'(DIV10_MUL);
      s2_cur  <= VAL_W'(s1_prod[PROD1_W-1:CUR_SHIFT]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        win_sum[i] <= '0;
        win_min[i] <= '1;
        win_max[i] <= '0;
        win_cnt[i] <= '0;
      end
    end else if (adv && s2_valid) begin
      if (last) begin
        win_sum[s2_ch] <= '0;
        win_min[s2_ch] <= '1;
        win_max[s2_ch] <= '0;
        win_cnt[s2_ch] <= '0;
      end else begin
        win_sum[s2_ch] <= sum_next;
        win_min[s2_ch] <= min_next;
        win_max[s2_ch] <= max_next;
        win_cnt[s2_ch] <= win_cnt[s2_ch] + 1'b1;
      end
    end
  end

endmodule

// ----- hdl/dctm_queue.sv -----
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dctm_queue import dctm_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !full)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, !empty)
  `ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)
  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, count <= CW'(DEPTH))

endmodule

// ----- hdl/dctm_back.sv -----
`timescale 1ns / 1ps

module dctm_back import dctm_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           empty,
  input  logic [entry_width(WINDOW)-1:0] head,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_ch,
  output logic [VAL_W-1:0]               out_val
);

  localparam int SW    = sum_width(WINDOW);
  localparam int EW    = entry_width(WINDOW);
  localparam int DIV   = WINDOW - 2;
  localparam int MW    = SW + 1;
  localparam int PW    = SW + MW;
  // Reciprocal rounded down; the estimate is low by at most one.
  localparam int RECIP = (2 ** SW) / DIV;

  logic               h_ch;
  logic [SW-1:0]      h_sum;
  logic [VAL_W-1:0]   h_min;
  logic [VAL_W-1:0]   h_max;

  logic               b1_valid;
  logic               b1_ch;
  logic [SW-1:0]      b1_x;
  logic               b2_valid;
  logic               b2_ch;
  logic [SW-1:0]      b2_x;
  logic [SW-1:0]      b2_q;

  logic [PW-1:0]      qprod;
  logic [SW-1:0]      qd;
  logic [SW-1:0]      rem;
  logic [SW-1:0]      qfix;
  logic               adv;

  assign h_ch  = head[EW-1];
  assign h_sum = head[2*VAL_W +: SW];
  assign h_min = head[VAL_W +: VAL_W];
  assign h_max = head[0 +: VAL_W];

  assign adv = !out_valid || out_ready;
  assign pop = !empty && adv;

  assign qprod = PW'(b1_x) * PW'(RECIP);
  assign qd    = b2_q * SW'(DIV);
  assign rem   = b2_x - qd;
  assign qfix  = (rem >= SW'(DIV)) ? b2_q + 1'b1 : b2_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      b1_valid  <= pop;
      b2_valid  <= b1_valid;
      out_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_ch   <= h_ch;
      b1_x    <= h_sum - SW'(h_min) - SW'(h_max);
      b2_ch   <= b1_ch;
      b2_x    <= b1_x;
      b2_q    <= qprod[SW +: SW];
      out_ch  <= b2_ch;
      out_val <= VAL_W'(qfix);
    end
  end

endmodule

// ----- hdl/dual_channel_trimmed_mean_adc_filter.sv -----
`timescale 1ns / 1ps

// Dual-channel trimmed-mean filter for a 12-bit converter.
// Input requests arrive on the s_ group: s_tdata[11:0] carries the raw reading and
// s_tuser picks the channel (0 voltage, 1 current). Each reading is scaled by its
// channel's formula and added into that channel's running window of WINDOW samples.
// When a window completes, one request leaves on the m_ group: m_tuser names the
// channel and m_tdata[11:0] holds the window mean with its minimum and maximum dropped.
// Throughput is one input request per cycle unless a completed window finds the queue
// full; a two-stage scaling pipeline feeds the window accumulators, updated per sample.
// On the way to m_tvalid, the accepting edge loads the first front stage, and the request
// then passes the second front stage, the queue, a subtract stage, a reciprocal multiply
// and a correction stage, each a register of its own.
// A small queue sits between the front and the divide pipeline, so a stalled
// receiver only stops intake once the queue fills and a further window completes.
// Reset clears both windows (sum zero, min all ones, max zero, count zero) and drops
// any request in flight; no warm-up is needed afterward.
module dual_channel_trimmed_mean_adc_filter import dctm_pkg::*; #(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [11:0] raw_sample, [15:12] zero
  input  logic               s_tuser,   // [0] channel
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [11:0] filtered_value, [15:12] zero
  output logic               m_tuser    // [0] out_channel
);

  localparam int EW = entry_width(WINDOW);

  logic          q_push;
  logic [EW-1:0] q_push_data;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  logic [EW-1:0] q_head;
  logic [VAL_W-1:0] out_val;

  // Front: scaling pipeline and per-channel window accumulators.
  dctm_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_channel (s_tuser),
    .in_raw     (s_tdata[RAW_W-1:0]),
    .queue_full (q_full),
    .push       (q_push),
    .push_data  (q_push_data)
  );

  // Completed windows wait here for the divider.
  dctm_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back: trimmed sum, divide by WINDOW-2, output register.
  dctm_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ch    (m_tuser),
    .out_val   (out_val)
  );

  assign m_tdata = {{(TDATA_W - VAL_W){1'b0}}, out_val};

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the dual-channel trimmed-mean filter.
// Each input request carries a raw reading and a channel tag. A monitor sees every
// accepted input and folds it into a per-channel model of the window: scaled value,
// running sum, minimum, maximum and count. When a window fills, the monitor queues
// the expected trimmed mean. Each output request is compared with the oldest queued
// mean. Both sides of the stream idle in random bursts for most of the run, and the
// closing phase runs at full rate.
module testbench;
  import dctm_pkg::*;

  localparam int FILTER_WINDOW = WINDOW_DEF;
  // Cycles with no handshake on either side before the run is declared hung.
  localparam int STALL_LIMIT   = 2000;
  // Cycles to watch for stray output requests once nothing is pending.
  localparam int TAIL_CYCLES   = 20;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic             channel;
    logic [VAL_W-1:0] value;
  } mean_result_t;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata;
  logic               s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tuser;

  // Model of each channel's open window.
  int unsigned      win_sum   [2];
  logic [VAL_W-1:0] win_min   [2];
  logic [VAL_W-1:0] win_max   [2];
  int unsigned      win_count [2];

  // Trimmed means that the block still owes, oldest first.
  mean_result_t pending_means [$];

  int unsigned err_count;
  int unsigned quiet_cycles;
  // When set, both the sender and the receiver insert random idle bursts.
  bit          idle_on;

  dual_channel_trimmed_mean_adc_filter #(
    .WINDOW(FILTER_WINDOW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Scaling of one reading. Voltage is offset and divided down to tenths,
  // current is a plain fractional multiply. Both divisions truncate.
  function automatic logic [VAL_W-1:0] scale_reading(logic ch, logic [RAW_W-1:0] raw);
    int unsigned r;
    r = 32'(raw);
    if (ch == CH_VOLT) return VAL_W'(((r * 33000) / 4096 + 650) / 10);
    return VAL_W'((r * 3300) / 16384);
  endfunction

  function automatic void clear_window(int ch);
    win_sum[ch]   = 0;
    win_min[ch]   = '1;
    win_max[ch]   = '0;
    win_count[ch] = 0;
  endfunction

  // Adds one accepted reading to its window. A full window yields the mean
  // of its samples with one minimum and one maximum left out, then reopens.
  function automatic void fold_sample(logic ch, logic [RAW_W-1:0] raw);
    int               idx;
    logic [VAL_W-1:0] v;
    mean_result_t     mean;
    idx = int'(ch);
    v   = scale_reading(ch, raw);
    win_sum[idx] += 32'(v);
    if (v < win_min[idx]) win_min[idx] = v;
    if (v > win_max[idx]) win_max[idx] = v;
    win_count[idx]++;
    if (win_count[idx] >= FILTER_WINDOW) begin
      mean.channel = ch;
      mean.value   = VAL_W'((win_sum[idx] - 32'(win_min[idx]) - 32'(win_max[idx]))
                            / (FILTER_WINDOW - 2));
      pending_means.push_back(mean);
      clear_window(idx);
    end
  endfunction

  function automatic void note_mismatch(string what, mean_result_t want, mean_result_t got);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%0t: %s: expected channel %0d value %0d, got channel %0d value %0d",
               $realtime, what, want.channel, want.value, got.channel, got.value);
  endfunction

  // Monitor. The output side is checked before the input side is folded in,
  // so a request accepted at this edge never meets its own result here.
  always @(posedge clk) begin
    mean_result_t got;
    mean_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.channel = m_tuser;
        got.value   = m_tdata[VAL_W-1:0];
        if (pending_means.size() == 0) begin
          note_mismatch("output request with nothing pending", '0, got);
        end else begin
          want = pending_means.pop_front();
          if (got.channel != want.channel)
            note_mismatch("channel mismatch", want, got);
          else if (got.value != want.value)
            note_mismatch("filtered value mismatch", want, got);
        end
      end
      if (s_tvalid && s_tready) fold_sample(s_tuser, s_tdata[RAW_W-1:0]);
    end
  end

  // Watchdog: a correct block never goes this long without a handshake,
  // whatever the idle bursts on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Receiver. Backpressure comes in bursts of random length; after each burst m_tready
  // is raised again before another burst can start.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Offers one input request and returns at the edge where it is accepted.
  task automatic send_sample(logic ch, logic [RAW_W-1:0] raw);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= ch;
    s_tdata  <= TDATA_W'(raw);
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  // Withdraws the sender and waits until every owed mean has come out.
  task automatic hold_off();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
  endtask

  // Both channels interleaved, so the voltage window completes while the current
  // window lacks one sample. The readings hit both ends of the range and put
  // every raw bit at both values; the current channel sees the complement of
  // each voltage reading. Two extra current readings leave a partial window open.
  task automatic test_directed_extremes();
    logic [RAW_W-1:0] pattern [10];
    pattern = '{12'h000, 12'hFFF, 12'h001, 12'h800, 12'hFFE,
                12'h555, 12'hAAA, 12'h000, 12'hFFF, 12'h064};
    for (int i = 0; i < 10; i++) begin
      send_sample(CH_VOLT, pattern[i]);
      send_sample(CH_CUR, ~pattern[i]);
    end
    send_sample(CH_CUR, 12'hFFF);
    send_sample(CH_CUR, 12'h000);
    hold_off();
  endtask

  // Random channel and reading, weighted toward the ends of the range and toward
  // small values, where the scaled samples tie most often. Every so often the
  // sender stops until the block has caught up.
  task automatic test_random_mix(int count);
    logic [RAW_W-1:0] raw;
    logic             ch;
    int               pick;
    for (int i = 0; i < count; i++) begin
      ch   = 1'($urandom_range(0, 1));
      pick = int'($urandom_range(0, 9));
      if (pick < 6)
        raw = RAW_W'($urandom_range(0, 4095));
      else if (pick < 8)
        raw = ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
      else if (pick < 9)
        raw = RAW_W'($urandom_range(0, 31));
      else
        raw = RAW_W'($urandom_range(4064, 4095));
      send_sample(ch, raw);
      if (i % 150 == 149) hold_off();
    end
  endtask

  // Runs of WINDOW samples on one channel at a time: some with every sample equal
  // and some that climb steadily. A run need not line up with a window boundary.
  task automatic test_equal_runs();
    logic             ch;
    logic [RAW_W-1:0] base;
    bit               climb;
    for (int w = 0; w < 7; w++) begin
      ch    = 1'($urandom_range(0, 1));
      base  = RAW_W'($urandom_range(0, 4095 - 400));
      climb = w[0];
      for (int k = 0; k < FILTER_WINDOW; k++)
        send_sample(ch, climb ? base + RAW_W'(k * 37) : base);
    end
  endtask

  // Closing phase at full rate on both sides.
  task automatic test_back_to_back(int count);
    for (int i = 0; i < count; i++)
      send_sample(1'($urandom_range(0, 1)), RAW_W'($urandom_range(0, 4095)));
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = CH_VOLT;
    idle_on      = 1'b0;
    err_count    = 0;
    quiet_cycles = 0;
    clear_window(CH_VOLT);
    clear_window(CH_CUR);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_extremes();
    idle_on = 1'b1;
    test_random_mix(500);
    test_equal_runs();
    idle_on = 1'b0;
    test_back_to_back(60);

    // Everything owed must arrive, and nothing more may follow it.
    hold_off();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/dctm_pkg.sv
hdl/dctm_front.sv
hdl/dctm_queue.sv
hdl/dctm_back.sv
hdl/dual_channel_trimmed_mean_adc_filter.sv
dv/testbench.sv
